// ----- src/hpcf_pkg.sv -----
`default_nettype none
package hpcf_pkg;

  // Counter width for command byte position and command length
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    FN_STROBE = 2'd0,
    FN_WRITE  = 2'd1,
    FN_READ   = 2'd2,
    FN_POP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_WRITE_OK  = 2'd1,
    ST_CMD_READY = 2'd2
  } status_t;

  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_POP  = 1'b1
  } back_state_t;

  // Known opcodes
  localparam logic [7:0] OP_08 = 8'h08;
  localparam logic [7:0] OP_0A = 8'h0A;
  localparam logic [7:0] OP_28 = 8'h28;
  localparam logic [7:0] OP_2A = 8'h2A;
  localparam logic [7:0] OP_01 = 8'h01;
  localparam logic [7:0] OP_11 = 8'h11;
  localparam logic [7:0] OP_12 = 8'h12;
  localparam logic [7:0] OP_03 = 8'h03;
  localparam logic [7:0] OP_10 = 8'h10;
  localparam logic [7:0] OP_30 = 8'h30;
  localparam logic [7:0] OP_31 = 8'h31;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic             unknown;
  } op_info_t;

  // Decoded word passed from front to back
  typedef struct packed {
    func_t            func;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
    logic             unknown;
  } dec_item_t;

  // One result word
  typedef struct packed {
    logic [1:0] status;
    logic       command_byte_valid;
    logic [7:0] command_byte;
    logic [3:0] command_index;
    logic       command_last;
    logic       bad_command;
    logic       pop_valid;
    logic [7:0] pop_data;
    logic       data_lost;
    logic       reboot_request;
  } res_t;

  function automatic op_info_t opcode_info(logic [7:0] op, logic [CNT_W-1:0] max_len);
    op_info_t info;
    info.unknown = 1'b0;
    case (op)
      OP_08, OP_0A, OP_28, OP_2A, OP_01: info.len = CNT_W'(4);
      OP_11:                             info.len = max_len;
      OP_12:                             info.len = CNT_W'(3);
      OP_03, OP_10, OP_30, OP_31:        info.len = CNT_W'(1);
      default: begin
        info.len     = CNT_W'(1);
        info.unknown = 1'b1;
      end
    endcase
    return info;
  endfunction

endpackage
`default_nettype wire

// ----- src/hpcf_if.sv -----
`default_nettype none
interface hpcf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface hpcf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       command_byte_valid;
  logic [7:0] command_byte;
  logic [3:0] command_index;
  logic       command_last;
  logic       bad_command;
  logic       pop_valid;
  logic [7:0] pop_data;
  logic       data_lost;
  logic       reboot_request;

  modport source (
    output valid, output status, output command_byte_valid, output command_byte,
    output command_index, output command_last, output bad_command, output pop_valid,
    output pop_data, output data_lost, output reboot_request, input ready
  );
  modport sink (
    input valid, input status, input command_byte_valid, input command_byte,
    input command_index, input command_last, input bad_command, input pop_valid,
    input pop_data, input data_lost, input reboot_request, output ready
  );
endinterface
`default_nettype wire

// ----- src/hpcf_ram.sv -----
`default_nettype none
module hpcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/hpcf_front.sv -----
`default_nettype none
module hpcf_front #(
  parameter int CMD_MAX_BYTES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  hpcf_in_if.sink                in_port,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output hpcf_pkg::dec_item_t    push_item
);

  logic                vld_r, vld_nxt;
  hpcf_pkg::dec_item_t item_r, item_nxt;
  hpcf_pkg::op_info_t  info;
  logic                accept;

  assign in_port.ready = !vld_r || push_ready;
  assign accept        = in_port.valid && in_port.ready;

  // Opcode lookup is done for every word; back uses it only on the first command byte
  assign info = hpcf_pkg::opcode_info(in_port.data_byte, hpcf_pkg::CNT_W'(CMD_MAX_BYTES));

  always_comb begin
    vld_nxt  = vld_r && !push_ready;
    item_nxt = item_r;
    if (accept) begin
      vld_nxt          = 1'b1;
      item_nxt.func    = hpcf_pkg::func_t'(in_port.func);
      item_nxt.data    = in_port.data_byte;
      item_nxt.len     = info.len;
      item_nxt.unknown = info.unknown;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = vld_r;
  assign push_item  = item_r;

endmodule
`default_nettype wire

// ----- src/hpcf_queue.sv -----
`default_nettype none
module hpcf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire hpcf_pkg::dec_item_t  push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output hpcf_pkg::dec_item_t       pop_item
);

  // Two-entry decoupling queue
  hpcf_pkg::dec_item_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- src/hpcf_back.sv -----
`default_nettype none
module hpcf_back #(
  parameter int FIFO_DEPTH    = 256,
  parameter int CMD_MAX_BYTES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire hpcf_pkg::dec_item_t  q_item,
  hpcf_out_if.source                out_port
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = hpcf_pkg::CNT_W;

  hpcf_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic              full_r, full_nxt;
  logic              open_r, open_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  hpcf_pkg::status_t status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  hpcf_pkg::res_t    res_r, res_nxt;

  logic              slot_free, take, nonempty;
  logic              ram_we, ram_re;
  logic [7:0]        ram_rdata;

  assign slot_free = !out_valid_r || out_port.ready;
  assign take      = (state_r == hpcf_pkg::BK_EXEC) && q_valid && slot_free;
  assign q_ready   = take;
  assign nonempty  = full_r || (rp_r != wp_r);
  assign wp_inc    = (wp_r == AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign rp_inc    = (rp_r == AW'(FIFO_DEPTH - 1)) ? '0 : rp_r + AW'(1);

  hpcf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (q_item.data),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpcf_pkg::BK_EXEC: begin
        if (take && q_item.func == hpcf_pkg::FN_POP && nonempty) begin
          state_nxt = hpcf_pkg::BK_POP;
        end
      end
      hpcf_pkg::BK_POP: state_nxt = hpcf_pkg::BK_EXEC;
      default:          state_nxt = hpcf_pkg::BK_EXEC;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [CW-1:0] c_len;
    logic [CW-1:0] c_cnt;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    full_nxt      = full_r;
    open_nxt      = open_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_port.ready;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    c_len         = len_r;
    c_cnt         = cnt_r;

    case (state_r)
      hpcf_pkg::BK_POP: begin
        // read data for the pop issued last cycle
        res_nxt           = '0;
        res_nxt.status    = status_r;
        res_nxt.pop_valid = 1'b1;
        res_nxt.pop_data  = ram_rdata;
        out_valid_nxt     = 1'b1;
      end
      hpcf_pkg::BK_EXEC: begin
        if (take) begin
          res_nxt = '0;
          case (q_item.func)
            hpcf_pkg::FN_STROBE: begin
              if (open_r) begin
                // strobe inside an open command: back to reset state
                wp_nxt                 = '0;
                rp_nxt                 = '0;
                full_nxt               = 1'b0;
                open_nxt               = 1'b0;
                cnt_nxt                = '0;
                len_nxt                = CW'(CMD_MAX_BYTES);
                status_nxt             = hpcf_pkg::ST_CMD_READY;
                res_nxt.reboot_request = 1'b1;
              end else begin
                cnt_nxt    = '0;
                open_nxt   = 1'b1;
                status_nxt = hpcf_pkg::ST_WRITE_OK;
              end
            end
            hpcf_pkg::FN_WRITE: begin
              if (open_r && (cnt_r < len_r)) begin
                if (cnt_r == '0) begin
                  c_len               = q_item.len;
                  res_nxt.bad_command = q_item.unknown;
                end
                c_cnt                      = cnt_r + CW'(1);
                res_nxt.command_byte_valid = 1'b1;
                res_nxt.command_byte       = q_item.data;
                res_nxt.command_index      = cnt_r[3:0];
                res_nxt.command_last       = (c_cnt == c_len);
                status_nxt = full_r ? hpcf_pkg::ST_BUSY : hpcf_pkg::ST_WRITE_OK;
              end else if (!full_r) begin
                ram_we     = 1'b1;
                wp_nxt     = wp_inc;
                full_nxt   = (wp_inc == rp_r);
                status_nxt = (wp_inc == rp_r) ? hpcf_pkg::ST_BUSY : hpcf_pkg::ST_WRITE_OK;
              end else begin
                res_nxt.data_lost = 1'b1;
                status_nxt        = hpcf_pkg::ST_BUSY;
              end
              cnt_nxt  = c_cnt;
              len_nxt  = c_len;
              open_nxt = open_r && (c_cnt != c_len);
            end
            hpcf_pkg::FN_READ: begin
              status_nxt = hpcf_pkg::ST_BUSY;
            end
            hpcf_pkg::FN_POP: begin
              if (nonempty) begin
                ram_re   = 1'b1;
                rp_nxt   = rp_inc;
                full_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
          res_nxt.status = status_nxt;
          // a pop that hits data finishes in the next state
          out_valid_nxt  = !(q_item.func == hpcf_pkg::FN_POP && nonempty);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpcf_pkg::BK_EXEC;
      wp_r        <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
      open_r      <= 1'b0;
      cnt_r       <= '0;
      len_r       <= CW'(CMD_MAX_BYTES);
      status_r    <= hpcf_pkg::ST_CMD_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      full_r      <= full_nxt;
      open_r      <= open_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_port.valid              = out_valid_r;
  assign out_port.status             = res_r.status;
  assign out_port.command_byte_valid = res_r.command_byte_valid;
  assign out_port.command_byte       = res_r.command_byte;
  assign out_port.command_index      = res_r.command_index;
  assign out_port.command_last       = res_r.command_last;
  assign out_port.bad_command        = res_r.bad_command;
  assign out_port.pop_valid          = res_r.pop_valid;
  assign out_port.pop_data           = res_r.pop_data;
  assign out_port.data_lost          = res_r.data_lost;
  assign out_port.reboot_request     = res_r.reboot_request;

endmodule
`default_nettype wire

// ----- src/host_port_command_fifo.sv -----
// Path: front register, queue, back register; a data pop adds the RAM read register.
// Throughput: one word per cycle while out_port is ready; a pop that returns data holds
//   the back end in its pop state, set by the registered read port of the FIFO RAM.
// Reset: synchronous active-low rst_n clears pointers, flags, queue and output valid;
//   status comes up as command ready. FIFO RAM contents are not cleared.
`default_nettype none
module host_port_command_fifo #(
  parameter int FIFO_DEPTH    = 256,
  parameter int CMD_MAX_BYTES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hpcf_in_if.sink    in_port,
  hpcf_out_if.source out_port
);

  // front -> queue
  logic                fr_valid, fr_ready;
  hpcf_pkg::dec_item_t fr_item;
  // queue -> back
  logic                bk_valid, bk_ready;
  hpcf_pkg::dec_item_t bk_item;

  // Front: input register plus opcode lookup
  hpcf_front #(
    .CMD_MAX_BYTES (CMD_MAX_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_port    (in_port),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item)
  );

  // Two-word queue lets the host side keep going while the back end handles a pop
  hpcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_item   (bk_item)
  );

  // Back: command tracking, ring FIFO, status, output register
  hpcf_back #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .CMD_MAX_BYTES (CMD_MAX_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (bk_valid),
    .q_ready  (bk_ready),
    .q_item   (bk_item),
    .out_port (out_port)
  );

endmodule
`default_nettype wire
